>>> src/mlfq_pkg.sv
package mlfq_pkg;

   // Sizing of the job store.
   localparam int MAX_JOBS   = 16;
   localparam int NUM_LEVELS = 3;
   localparam int SLOT_W     = $clog2(MAX_JOBS);
   localparam int CNT_W      = $clog2(MAX_JOBS + 1);
   localparam int ADDR_W     = $clog2(NUM_LEVELS * MAX_JOBS);
   localparam int LVL_W      = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_W      = 16;

   // Level codes.
   localparam logic [LVL_W-1:0] LEVEL_TOP    = 2'd0;
   localparam logic [LVL_W-1:0] LEVEL_MID    = 2'd1;
   localparam logic [LVL_W-1:0] LEVEL_LOW    = 2'd2;
   localparam logic [LVL_W-1:0] LEVEL_NONE   = 2'd3;

   // Request opcodes.
   localparam logic OP_ARRIVAL = 1'b0;
   localparam logic OP_TICK    = 1'b1;

   // Result event codes.
   localparam logic [2:0] EV_ACCEPTED  = 3'd0;
   localparam logic [2:0] EV_DROPPED   = 3'd1;
   localparam logic [2:0] EV_IDLE      = 3'd2;
   localparam logic [2:0] EV_RAN       = 3'd3;
   localparam logic [2:0] EV_COMPLETED = 3'd4;
   localparam logic [2:0] EV_DEMOTED   = 3'd5;
   localparam logic [2:0] EV_ROTATED   = 3'd6;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM0 = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM1 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BOOST    = 2'd3;

   typedef struct packed {
      logic        opcode;
      logic [7:0]  job_id;
      logic [15:0] job_length;
   } req_type;

   typedef struct packed {
      logic [2:0] event_res;
      logic [7:0] served_id;
      logic [1:0] served_level;
      logic       boosted;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  id;
      logic [15:0] rem;
   } job_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BOOST_RD,
      ST_BOOST_WR,
      ST_SERVE_SEL,
      ST_SERVE_EXEC
   } state_type;

   // Store address of a slot within a level's circular queue.
   function automatic logic [ADDR_W-1:0] mem_addr(input logic [LVL_W-1:0] lv,
                                                  input logic [SLOT_W-1:0] slot);
      return ADDR_W'(lv) * ADDR_W'(MAX_JOBS) + ADDR_W'(slot);
   endfunction

   // Circular queue pointer advance.
   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] x);
      return (x == SLOT_W'(MAX_JOBS - 1)) ? '0 : x + SLOT_W'(1);
   endfunction

endpackage

>>> src/multilevel_feedback_queue_scheduler_top.sv
// Three-level feedback queue scheduler.
// Requests: an item is transferred when start is high and busy is low. An arrival
// (opcode 0) appends a job to the top queue or reports it dropped when the store
// holds MAX_JOBS jobs. A tick (opcode 1) advances the boost counter, moves all
// lower-level jobs back to the top queue at the boost period, then serves one
// time unit of the chosen head job.
// Results: exactly one per request, shown on rsp_data for one cycle with rsp_valid
// high. The receiver cannot stall; results are never held back.
// Timing: an arrival is answered in the cycle after its transfer and busy stays low.
// A tick that serves a job steps through select, a registered store read and update;
// a tick with nothing to serve ends after select. A boost adds a store read and a
// store write per job moved, and one more read step before select.
// The job store is one single-port-write memory with a registered read port;
// every store access of a tick passes through it in turn, which sets the rate.
// Configuration: csr_we writes register csr_index (0..2 quanta, 3 boost period)
// and should only be used while the block is idle.
// Reset: synchronous, active high; queues empty, registers at defaults; the
// store needs no clearing pass since only written entries are ever read.
module multilevel_feedback_queue_scheduler_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  mlfq_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   output mlfq_pkg::rsp_type                 rsp_data,
   input  logic                              csr_we,
   input  logic [mlfq_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mlfq_pkg::CSR_W-1:0]        csr_wdata
);

   localparam int SW = mlfq_pkg::SLOT_W;
   localparam int CW = mlfq_pkg::CNT_W;
   localparam int LW = mlfq_pkg::LVL_W;
   localparam int NL = mlfq_pkg::NUM_LEVELS;

   mlfq_pkg::state_type state_ff, state_in;

   logic [15:0] quantum0_ff, quantum0_in;
   logic [15:0] quantum1_ff, quantum1_in;
   logic [15:0] quantum2_ff, quantum2_in;
   logic [15:0] period_ff,   period_in;

   logic [SW-1:0] head_ff  [NL];
   logic [SW-1:0] head_in  [NL];
   logic [SW-1:0] tail_ff  [NL];
   logic [SW-1:0] tail_in  [NL];
   logic [CW-1:0] count_ff [NL];
   logic [CW-1:0] count_in [NL];
   logic [15:0]   used_ff  [NL];
   logic [15:0]   used_in  [NL];

   logic [LW-1:0] running_ff,  running_in;
   logic [LW-1:0] serve_lv_ff, serve_lv_in;
   logic [LW-1:0] src_lv_ff,   src_lv_in;
   logic [15:0]   bcnt_ff,     bcnt_in;
   logic          boosted_ff,  boosted_in;

   logic              rsp_valid_ff, rsp_valid_in;
   mlfq_pkg::rsp_type rsp_ff,       rsp_in;

   // Job store and its port controls.
   mlfq_pkg::job_entry_type store_mem [NL * mlfq_pkg::MAX_JOBS];
   mlfq_pkg::job_entry_type rd_data_ff;
   mlfq_pkg::job_entry_type mem_wdata;
   logic                        mem_we;
   logic                        mem_re;
   logic [mlfq_pkg::ADDR_W-1:0] mem_waddr;
   logic [mlfq_pkg::ADDR_W-1:0] mem_raddr;

   // Shared decode.
   logic [CW+1:0] total_jobs;
   logic [15:0]   bcnt_next;
   logic          boost_hit;
   logic          lower_busy;
   logic [LW-1:0] sel_lv;
   logic          sel_found;

   assign busy      = (state_ff != mlfq_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign total_jobs = (CW+2)'(count_ff[0]) + (CW+2)'(count_ff[1]) + (CW+2)'(count_ff[2]);
   assign bcnt_next  = bcnt_ff + 16'd1;
   assign boost_hit  = (bcnt_next >= period_ff);
   assign lower_busy = (count_ff[1] != '0) || (count_ff[2] != '0);

   // Pick the highest non-empty level that the running level allows.
   always_comb begin
      sel_lv    = mlfq_pkg::LEVEL_NONE;
      sel_found = 1'b0;
      for (int k = 0; k < NL; k++) begin
         if (!sel_found && count_ff[k] != '0 &&
             (running_ff == mlfq_pkg::LEVEL_NONE || running_ff == LW'(k))) begin
            sel_lv    = LW'(k);
            sel_found = 1'b1;
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mlfq_pkg::ST_IDLE: begin
            if (start && req_data.opcode == mlfq_pkg::OP_TICK) begin
               state_in = boost_hit ? mlfq_pkg::ST_BOOST_RD : mlfq_pkg::ST_SERVE_SEL;
            end
         end
         mlfq_pkg::ST_BOOST_RD: begin
            state_in = lower_busy ? mlfq_pkg::ST_BOOST_WR : mlfq_pkg::ST_SERVE_SEL;
         end
         mlfq_pkg::ST_BOOST_WR: begin
            state_in = mlfq_pkg::ST_BOOST_RD;
         end
         mlfq_pkg::ST_SERVE_SEL: begin
            state_in = sel_found ? mlfq_pkg::ST_SERVE_EXEC : mlfq_pkg::ST_IDLE;
         end
         mlfq_pkg::ST_SERVE_EXEC: begin
            state_in = mlfq_pkg::ST_IDLE;
         end
         default: begin
            state_in = mlfq_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath, store accesses and results.
   always_comb begin
      mlfq_pkg::job_entry_type entry;
      logic [LW-1:0] lv;
      logic [LW-1:0] dst;
      logic [15:0]   rem_dec;
      logic [15:0]   used_new;
      logic [15:0]   quantum;

      quantum0_in  = quantum0_ff;
      quantum1_in  = quantum1_ff;
      quantum2_in  = quantum2_ff;
      period_in    = period_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      used_in      = used_ff;
      running_in   = running_ff;
      serve_lv_in  = serve_lv_ff;
      src_lv_in    = src_lv_ff;
      bcnt_in      = bcnt_ff;
      boosted_in   = boosted_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = '0;
      mem_raddr    = '0;
      mem_wdata    = rd_data_ff;
      entry        = rd_data_ff;
      lv           = serve_lv_ff;
      dst          = serve_lv_ff;
      rem_dec      = rd_data_ff.rem - 16'd1;
      used_new     = '0;
      quantum      = '0;

      // Configuration writes.
      if (csr_we) begin
         case (csr_index)
            mlfq_pkg::CSR_QUANTUM0: quantum0_in = csr_wdata;
            mlfq_pkg::CSR_QUANTUM1: quantum1_in = csr_wdata;
            mlfq_pkg::CSR_QUANTUM2: quantum2_in = csr_wdata;
            mlfq_pkg::CSR_BOOST:    period_in   = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         mlfq_pkg::ST_IDLE: begin
            if (start) begin
               if (req_data.opcode == mlfq_pkg::OP_ARRIVAL) begin
                  // Arrival: append to the top queue unless the store is full.
                  rsp_valid_in        = 1'b1;
                  rsp_in.served_id    = req_data.job_id;
                  rsp_in.served_level = mlfq_pkg::LEVEL_TOP;
                  rsp_in.boosted      = 1'b0;
                  if (total_jobs >= (CW+2)'(mlfq_pkg::MAX_JOBS)) begin
                     rsp_in.event_res = mlfq_pkg::EV_DROPPED;
                  end else begin
                     rsp_in.event_res = mlfq_pkg::EV_ACCEPTED;
                     mem_we           = 1'b1;
                     mem_waddr        = mlfq_pkg::mem_addr(mlfq_pkg::LEVEL_TOP, tail_ff[0]);
                     mem_wdata.id     = req_data.job_id;
                     mem_wdata.rem    = req_data.job_length;
                     tail_in[0]       = mlfq_pkg::next_slot(tail_ff[0]);
                     count_in[0]      = count_ff[0] + CW'(1);
                  end
               end else begin
                  // Tick: advance the boost counter and arm a boost if due.
                  if (boost_hit) begin
                     bcnt_in    = '0;
                     boosted_in = 1'b1;
                     running_in = mlfq_pkg::LEVEL_NONE;
                     for (int k = 0; k < NL; k++) begin
                        used_in[k] = '0;
                     end
                  end else begin
                     bcnt_in    = bcnt_next;
                     boosted_in = 1'b0;
                  end
               end
            end
         end

         mlfq_pkg::ST_BOOST_RD: begin
            // Fetch the head of the middle queue first, then the lowest one.
            if (count_ff[1] != '0) begin
               src_lv_in = mlfq_pkg::LEVEL_MID;
               mem_re    = 1'b1;
               mem_raddr = mlfq_pkg::mem_addr(mlfq_pkg::LEVEL_MID, head_ff[1]);
            end else if (count_ff[2] != '0) begin
               src_lv_in = mlfq_pkg::LEVEL_LOW;
               mem_re    = 1'b1;
               mem_raddr = mlfq_pkg::mem_addr(mlfq_pkg::LEVEL_LOW, head_ff[2]);
            end
         end

         mlfq_pkg::ST_BOOST_WR: begin
            // Append the fetched job to the top queue and pop its source.
            mem_we              = 1'b1;
            mem_waddr           = mlfq_pkg::mem_addr(mlfq_pkg::LEVEL_TOP, tail_ff[0]);
            mem_wdata           = rd_data_ff;
            tail_in[0]          = mlfq_pkg::next_slot(tail_ff[0]);
            count_in[0]         = count_ff[0] + CW'(1);
            head_in[src_lv_ff]  = mlfq_pkg::next_slot(head_ff[src_lv_ff]);
            count_in[src_lv_ff] = count_ff[src_lv_ff] - CW'(1);
         end

         mlfq_pkg::ST_SERVE_SEL: begin
            serve_lv_in = sel_lv;
            if (sel_found) begin
               mem_re    = 1'b1;
               mem_raddr = mlfq_pkg::mem_addr(sel_lv, head_ff[sel_lv]);
            end else begin
               rsp_valid_in        = 1'b1;
               rsp_in.event_res    = mlfq_pkg::EV_IDLE;
               rsp_in.served_id    = '0;
               rsp_in.served_level = mlfq_pkg::LEVEL_TOP;
               rsp_in.boosted      = boosted_ff;
            end
         end

         mlfq_pkg::ST_SERVE_EXEC: begin
            // Serve one unit of the head job read last cycle.
            rsp_valid_in        = 1'b1;
            rsp_in.served_id    = entry.id;
            rsp_in.served_level = lv;
            rsp_in.boosted      = boosted_ff;
            running_in          = lv;
            case (lv)
               mlfq_pkg::LEVEL_TOP: quantum = quantum0_ff;
               mlfq_pkg::LEVEL_MID: quantum = quantum1_ff;
               default:             quantum = quantum2_ff;
            endcase
            used_new = (used_ff[lv] == 16'hFFFF) ? used_ff[lv] : used_ff[lv] + 16'd1;
            if (entry.rem <= 16'd1) begin
               // Completion.
               head_in[lv]      = mlfq_pkg::next_slot(head_ff[lv]);
               count_in[lv]     = count_ff[lv] - CW'(1);
               used_in[lv]      = '0;
               running_in       = mlfq_pkg::LEVEL_NONE;
               rsp_in.event_res = mlfq_pkg::EV_COMPLETED;
            end else if (used_new >= quantum) begin
               // Quantum expired: demote, or rotate within the lowest queue.
               dst = (lv == mlfq_pkg::LEVEL_LOW) ? lv : lv + LW'(1);
               head_in[lv]   = mlfq_pkg::next_slot(head_ff[lv]);
               tail_in[dst]  = mlfq_pkg::next_slot(tail_ff[dst]);
               mem_we        = 1'b1;
               mem_waddr     = mlfq_pkg::mem_addr(dst, tail_ff[dst]);
               mem_wdata.id  = entry.id;
               mem_wdata.rem = rem_dec;
               if (dst != lv) begin
                  count_in[lv]     = count_ff[lv] - CW'(1);
                  count_in[dst]    = count_ff[dst] + CW'(1);
                  rsp_in.event_res = mlfq_pkg::EV_DEMOTED;
               end else begin
                  rsp_in.event_res = mlfq_pkg::EV_ROTATED;
               end
               used_in[lv] = '0;
               running_in  = mlfq_pkg::LEVEL_NONE;
            end else begin
               // Keep running: write back the shortened remaining count.
               used_in[lv]      = used_new;
               mem_we           = 1'b1;
               mem_waddr        = mlfq_pkg::mem_addr(lv, head_ff[lv]);
               mem_wdata.id     = entry.id;
               mem_wdata.rem    = rem_dec;
               rsp_in.event_res = mlfq_pkg::EV_RAN;
            end
         end

         default: ;
      endcase
   end

   // Job store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= store_mem[mem_raddr];
      end
   end

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mlfq_pkg::ST_IDLE;
         quantum0_ff  <= 16'd2;
         quantum1_ff  <= 16'd5;
         quantum2_ff  <= 16'd10;
         period_ff    <= 16'd20;
         for (int k = 0; k < NL; k++) begin
            head_ff[k]  <= '0;
            tail_ff[k]  <= '0;
            count_ff[k] <= '0;
            used_ff[k]  <= '0;
         end
         running_ff   <= mlfq_pkg::LEVEL_NONE;
         serve_lv_ff  <= mlfq_pkg::LEVEL_TOP;
         src_lv_ff    <= mlfq_pkg::LEVEL_MID;
         bcnt_ff      <= '0;
         boosted_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         quantum0_ff  <= quantum0_in;
         quantum1_ff  <= quantum1_in;
         quantum2_ff  <= quantum2_in;
         period_ff    <= period_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         used_ff      <= used_in;
         running_ff   <= running_in;
         serve_lv_ff  <= serve_lv_in;
         src_lv_ff    <= src_lv_in;
         bcnt_ff      <= bcnt_in;
         boosted_ff   <= boosted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

`ifndef SYNTHESIS
   // The store never holds more jobs than it has room for.
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_jobs <= (CW+2)'(mlfq_pkg::MAX_JOBS))
      else $error("job count exceeds store size");

   // An arrival transfer is answered on the next cycle.
   a_arrival_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.opcode == mlfq_pkg::OP_ARRIVAL) |=> rsp_valid)
      else $error("arrival not answered");

   // Jobs are moved only after the boost counter has been cleared.
   a_boost_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mlfq_pkg::ST_BOOST_WR) |-> (bcnt_ff == '0 && boosted_ff))
      else $error("boost move without boost");

   // A result only follows an arrival transfer or work in progress.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy || start))
      else $error("unexpected result");
`endif

endmodule
